// File: src/sdf_pkg.sv
// Package for the stream duplicate filter.
// Holds the shared constants and the cell-to-cell link type.
// No dependencies.
package sdf_pkg;

  // Default number of cells, which is also the per-set input limit
  localparam int CAPACITY = 64;

  // Width of one stream value
  localparam int VALUE_W = 32;

  // Probe token handed from one cell to the next
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } link_t;

endpackage

// File: src/sdf_cell.sv
// One cell of the duplicate filter chain: a stored value and a probe stage.
// Depends on sdf_pkg (link_t, VALUE_W).
module sdf_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  sdf_pkg::link_t      link_in,
  input  logic [CNT_W-1:0]    count,
  output sdf_pkg::link_t      link_out,
  output logic                match
);

  sdf_pkg::link_t                probe;
  logic [sdf_pkg::VALUE_W-1:0]   stored_value;
  logic                          occupied;
  logic                          tail;

  // Cells below the distinct count hold a value; the first free one is the tail
  assign occupied = CNT_W'(INDEX) < count;
  assign tail     = CNT_W'(INDEX) == count;
  assign match    = probe.valid && occupied && (stored_value == probe.value);

  // Token moves on unless it hit here or landed in the tail cell
  assign link_out.valid = probe.valid && !match && !tail;
  assign link_out.value = probe.value;

  // Probe stage
  always_ff @(posedge clk) begin
    if (rst) begin
      probe.valid <= 1'b0;
    end else begin
      probe.valid <= link_in.valid;
    end
    probe.value <= link_in.value;
  end

  // A new distinct value lands in the tail cell
  always_ff @(posedge clk) begin
    if (probe.valid && tail) begin
      stored_value <= probe.value;
    end
  end

endmodule

// File: src/stream_duplicate_filter.sv
// Stream duplicate filter: passes each value only on its first occurrence
// within a set. Top level; depends on sdf_pkg and sdf_cell.
//
// Usage:
//   Input channel (valid/stall): value, last_of_set. One request per set
//   element; last_of_set closes the set and empties the store after it.
//   Output channel (result_valid/result_stall): unique_value and
//   distinct_count (distinct values so far in the set, this one included).
//   A repeated value gives no result. Once CAPACITY requests are taken in a
//   set, further ones are dropped without a result (last_of_set still ends
//   the set).
//   Timing: a request probes the cell chain one cell per cycle from cell 0.
//   A value matching cell k ends its probe there; a new value walks to the
//   first free cell, and its result is registered at the edge that ends
//   the probe. The next request is taken only after the probe ends, so a
//   probing request holds the input for its whole probe. A dropped request
//   starts no probe and does not hold the input.
//   Stall: an output register plus one skid entry hold results; while the
//   skid entry is full, stall stays high on the input side.
//   Reset: clears the counts, the probe tokens and both output entries.
module stream_duplicate_filter #(
  parameter  int CAPACITY = sdf_pkg::CAPACITY,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid,
  output logic                                stall,
  input  logic signed [sdf_pkg::VALUE_W-1:0]  value,
  input  logic                                last_of_set,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [sdf_pkg::VALUE_W-1:0]  unique_value,
  output logic [CNT_W-1:0]                    distinct_count
);

  sdf_pkg::link_t               link [CAPACITY+1];
  logic [CAPACITY-1:0]          match;

  logic                         busy;
  logic [PTR_W-1:0]             pos;
  logic [sdf_pkg::VALUE_W-1:0]  item_value;
  logic                         item_last;
  logic [CNT_W-1:0]             accepted_count;
  logic [CNT_W-1:0]             unique_count;

  logic                         skid_valid;
  logic [sdf_pkg::VALUE_W-1:0]  skid_value;
  logic [CNT_W-1:0]             skid_count;

  logic                         accept;
  logic                         room;
  logic                         launch;
  logic                         at_tail;
  logic                         hit;
  logic                         done;
  logic                         out_take;
  logic                         out_free;

  // Input handshake
  assign stall  = busy || skid_valid;
  assign accept = valid && !stall;
  assign room   = accepted_count < CNT_W'(CAPACITY);
  assign launch = accept && room;

  // Probe token enters cell 0
  assign link[0].valid = launch;
  assign link[0].value = value;

  // Cell chain; the link past the last cell goes nowhere
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    sdf_cell #(.INDEX(k), .CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (link[k]),
      .count    (unique_count),
      .link_out (link[k+1]),
      .match    (match[k])
    );
  end

  // Probe ends on a hit or on reaching the first free cell
  assign at_tail = busy && (CNT_W'(pos) == unique_count);
  assign hit     = busy && match[pos];
  assign done    = at_tail || hit;

  // Sequencer and set counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      pos            <= '0;
      accepted_count <= '0;
      unique_count   <= '0;
    end else if (done) begin
      busy <= 1'b0;
      if (item_last) begin
        accepted_count <= '0;
        unique_count   <= '0;
      end else if (at_tail) begin
        unique_count <= unique_count + CNT_W'(1);
      end
    end else if (busy) begin
      pos <= pos + PTR_W'(1);
    end else if (accept) begin
      if (room) begin
        busy           <= 1'b1;
        pos            <= '0;
        accepted_count <= accepted_count + CNT_W'(1);
      end else if (last_of_set) begin
        accepted_count <= '0;
        unique_count   <= '0;
      end
    end
  end

  // Request payload held for the result
  always_ff @(posedge clk) begin
    if (launch) begin
      item_value <= value;
      item_last  <= last_of_set;
    end
  end

  // Output register with one skid entry
  assign out_take = result_valid && !result_stall;
  assign out_free = !result_valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (at_tail) begin
      if (out_free) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid && out_free) begin
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (at_tail) begin
      if (out_free) begin
        unique_value   <= item_value;
        distinct_count <= unique_count + CNT_W'(1);
      end else begin
        skid_value <= item_value;
        skid_count <= unique_count + CNT_W'(1);
      end
    end else if (skid_valid && out_free) begin
      unique_value   <= skid_value;
      distinct_count <= skid_count;
    end
  end

endmodule

// File: src/sdf_checker.sv
// Port-level checks for the stream duplicate filter, bound to the top level.
// Depends on stream_duplicate_filter and sdf_pkg.
module sdf_checker #(
  parameter  int CAPACITY = sdf_pkg::CAPACITY,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [sdf_pkg::VALUE_W-1:0] unique_value,
  input logic [CNT_W-1:0]                   distinct_count
);

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(unique_value) && $stable(distinct_count))
    else $error("stalled result changed");

  // Distinct count stays within 1..CAPACITY
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> distinct_count != '0 && distinct_count <= CNT_W'(CAPACITY))
    else $error("distinct count out of range");

endmodule

bind stream_duplicate_filter sdf_checker #(.CAPACITY(CAPACITY)) u_sdf_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .unique_value   (unique_value),
  .distinct_count (distinct_count)
);
